// ===== hdl/tmr_byte_voter_unit_assert.svh =====
// Assertion macros for the byte voter checks.
// Both expect clk and rst_n in scope.
`ifndef TMR_BYTE_VOTER_UNIT_ASSERT_SVH
`define TMR_BYTE_VOTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TBV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TBV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tbv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_pkg
// Types and constants shared by the byte voter modules.
// ----------------------------------------------------------------------------
package tbv_pkg;

    localparam int ADDR_FIELD_BITS = 32;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int TOTAL_BITS      = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAM_LOW  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAM_HIGH = 1'b1;

    // valid-copy mask: bit0 = A, bit1 = B, bit2 = C
    typedef logic [2:0] copy_mask_t;

    localparam copy_mask_t MASK_ABC = 3'b111;
    localparam copy_mask_t MASK_BC  = 3'b110;
    localparam copy_mask_t MASK_AC  = 3'b101;
    localparam copy_mask_t MASK_NONE = 3'b000;

    typedef struct packed {
        logic                       first;
        logic                       last;
        logic [ADDR_FIELD_BITS-1:0] addr_a;
        logic [ADDR_FIELD_BITS-1:0] addr_b;
        logic [ADDR_FIELD_BITS-1:0] addr_c;
        logic [7:0]                 byte_a;
        logic [7:0]                 byte_b;
        logic [7:0]                 byte_c;
    } item_t;

    typedef struct packed {
        logic [7:0]            voted_byte;
        logic                  mismatch;
        logic                  fatal;
        logic                  run_end;
        logic                  run_good;
        logic [TOTAL_BITS-1:0] error_total;
        logic [TOTAL_BITS-1:0] corrected_total;
    } result_t;

    // registered input item, address check already folded into a mask
    typedef struct packed {
        logic       first;
        logic       last;
        copy_mask_t in_window;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
    } stage_t;

endpackage

// ===== hdl/tbv_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface tbv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== hdl/tmr_byte_voter_unit.sv =====
`timescale 1ns / 1ps
// Each byte triple passes the input register, then the result register, before its
// result is presented. Throughput: one byte triple per cycle while result.ready holds.
// The address window check sits ahead of the input
// register; the vote and the counter update sit between the two registers.
// Reset: copy mask clears, run healthy sets, counters and channel valids clear; ram_low = 0,
// ram_high = all ones. No clearing pass.
// ----------------------------------------------------------------------------
// tmr_byte_voter_unit
// Triple-redundant byte stream voter with RAM window check and error counters.
// ----------------------------------------------------------------------------
module tmr_byte_voter_unit #(
    parameter int ADDR_BITS  = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tbv_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tbv_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    tbv_stream_if.sink                          item,
    tbv_stream_if.source                        result
);
    import tbv_pkg::*;

    logic [CFG_DATA_BITS-1:0] ram_low_reg;
    logic [CFG_DATA_BITS-1:0] ram_low_next;
    logic [CFG_DATA_BITS-1:0] ram_high_reg;
    logic [CFG_DATA_BITS-1:0] ram_high_next;

    logic    stage_valid_reg;
    logic    stage_valid_next;
    stage_t  stage_reg;
    stage_t  stage_next;
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;
    result_t res_next;

    copy_mask_t in_window;
    logic       take;
    logic       advance;

    tbv_window #(
        .ADDR_BITS (ADDR_BITS)
    ) u_window (
        .ram_low   (ram_low_reg),
        .ram_high  (ram_high_reg),
        .addr_a    (item.data.addr_a),
        .addr_b    (item.data.addr_b),
        .addr_c    (item.data.addr_c),
        .in_window (in_window)
    );

    tbv_vote #(
        .COUNT_BITS (COUNT_BITS)
    ) u_vote (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .stage    (stage_reg),
        .res_next (res_next)
    );

    // the result register frees up in the same cycle it is taken
    assign advance    = stage_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;
    assign take       = item.valid && item.ready;

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    always_comb
    begin
        ram_low_next  = ram_low_reg;
        ram_high_next = ram_high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_RAM_LOW:  ram_low_next  = cfg_data;
                REG_RAM_HIGH: ram_high_next = cfg_data;
                default:      ;
            endcase
        end

        stage_next.first     = item.data.first;
        stage_next.last      = item.data.last;
        stage_next.in_window = in_window;
        stage_next.byte_a    = item.data.byte_a;
        stage_next.byte_b    = item.data.byte_b;
        stage_next.byte_c    = item.data.byte_c;

        if (take)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;

        if (advance)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_low_reg     <= '0;
            ram_high_reg    <= '1;
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            ram_low_reg     <= ram_low_next;
            ram_high_reg    <= ram_high_next;
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= stage_next;
        if (advance)
            res_reg <= res_next;
    end

endmodule

// ===== hdl/tbv_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_window
// Checks the three copy base addresses against the RAM window.
// ----------------------------------------------------------------------------
module tbv_window #(
    parameter int ADDR_BITS = 32
) (
    input  logic [tbv_pkg::CFG_DATA_BITS-1:0]   ram_low,
    input  logic [tbv_pkg::CFG_DATA_BITS-1:0]   ram_high,
    input  logic [tbv_pkg::ADDR_FIELD_BITS-1:0] addr_a,
    input  logic [tbv_pkg::ADDR_FIELD_BITS-1:0] addr_b,
    input  logic [tbv_pkg::ADDR_FIELD_BITS-1:0] addr_c,
    output tbv_pkg::copy_mask_t                 in_window
);
    import tbv_pkg::*;

    logic [ADDR_BITS-1:0] low_cut;
    logic [ADDR_BITS-1:0] high_cut;
    logic [ADDR_BITS-1:0] a_cut;
    logic [ADDR_BITS-1:0] b_cut;
    logic [ADDR_BITS-1:0] c_cut;

    // everything is cut (or zero-extended) to ADDR_BITS before compare
    assign low_cut  = ADDR_BITS'(ram_low);
    assign high_cut = ADDR_BITS'(ram_high);
    assign a_cut    = ADDR_BITS'(addr_a);
    assign b_cut    = ADDR_BITS'(addr_b);
    assign c_cut    = ADDR_BITS'(addr_c);

    assign in_window[0] = (a_cut >= low_cut) && (a_cut <= high_cut);
    assign in_window[1] = (b_cut >= low_cut) && (b_cut <= high_cut);
    assign in_window[2] = (c_cut >= low_cut) && (c_cut <= high_cut);

endmodule

// ===== hdl/tbv_vote.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_vote
// Majority vote of one byte triple plus the run state and saturating counters.
// ----------------------------------------------------------------------------
module tbv_vote #(
    parameter int COUNT_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  tbv_pkg::stage_t  stage,
    output tbv_pkg::result_t res_next
);
    import tbv_pkg::*;

    copy_mask_t            copy_mode_reg;
    copy_mask_t            copy_mode_next;
    logic                  run_healthy_reg;
    logic                  run_healthy_next;
    logic [COUNT_BITS-1:0] error_cnt_reg;
    logic [COUNT_BITS-1:0] error_cnt_next;
    logic [COUNT_BITS-1:0] corr_cnt_reg;
    logic [COUNT_BITS-1:0] corr_cnt_next;

    copy_mask_t mode;
    logic [1:0] n_valid;
    logic       too_few;
    logic       healthy_base;
    logic [7:0] maj;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] voted;
    logic       mism;
    logic       fatal;
    logic       err_inc;

    always_comb
    begin
        mode    = stage.first ? stage.in_window : copy_mode_reg;
        n_valid = 2'(mode[0]) + 2'(mode[1]) + 2'(mode[2]);
        too_few = (n_valid < 2'd2);
        healthy_base = stage.first ? !too_few : run_healthy_reg;

        maj = (stage.byte_a & stage.byte_b) | (stage.byte_a & stage.byte_c)
            | (stage.byte_b & stage.byte_c);

        // two-copy mode: x is the first valid copy in order A, B, C
        case (mode)
            MASK_BC:
            begin
                x = stage.byte_b;
                y = stage.byte_c;
            end
            MASK_AC:
            begin
                x = stage.byte_a;
                y = stage.byte_c;
            end
            default:
            begin
                x = stage.byte_a;
                y = stage.byte_b;
            end
        endcase

        if (mode == MASK_ABC)
        begin
            voted = maj;
            mism  = (stage.byte_a != stage.byte_b) || (stage.byte_a != stage.byte_c);
            fatal = (stage.byte_a != stage.byte_b) && (stage.byte_a != stage.byte_c)
                 && (stage.byte_b != stage.byte_c);
        end
        else if (n_valid == 2'd2)
        begin
            voted = x;
            mism  = (x != y);
            fatal = (x != y);
        end
        else
        begin
            voted = 8'd0;
            mism  = 1'b0;
            fatal = 1'b1;
        end

        // at most one error count per byte: too few copies never votes
        err_inc = (stage.first && too_few) || mism;

        copy_mode_next   = mode;
        run_healthy_next = healthy_base && !fatal;
        error_cnt_next   = (err_inc && (error_cnt_reg != '1))
                         ? error_cnt_reg + COUNT_BITS'(1) : error_cnt_reg;
        corr_cnt_next    = (mism && (corr_cnt_reg != '1))
                         ? corr_cnt_reg + COUNT_BITS'(1) : corr_cnt_reg;

        res_next.voted_byte      = voted;
        res_next.mismatch        = mism;
        res_next.fatal           = fatal;
        res_next.run_end         = stage.last;
        res_next.run_good        = stage.last && run_healthy_next;
        res_next.error_total     = TOTAL_BITS'(error_cnt_next);
        res_next.corrected_total = TOTAL_BITS'(corr_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_mode_reg   <= MASK_NONE;
            run_healthy_reg <= 1'b1;
            error_cnt_reg   <= '0;
            corr_cnt_reg    <= '0;
        end
        else if (step)
        begin
            copy_mode_reg   <= copy_mode_next;
            run_healthy_reg <= run_healthy_next;
            error_cnt_reg   <= error_cnt_next;
            corr_cnt_reg    <= corr_cnt_next;
        end
    end

endmodule

// ===== hdl/tbv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_checker
// Port-level checks on the voter result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "tmr_byte_voter_unit_assert.svh"

module tbv_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input tbv_pkg::result_t res
);
    import tbv_pkg::*;

    `TBV_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "stalled result changed")
    `TBV_ASSERT_IMP(a_good_at_end, res_valid && res.run_good, res.run_end, "run_good without run_end")
    `TBV_ASSERT_IMP(a_too_few_zero, res_valid && res.fatal && !res.mismatch, res.voted_byte == 8'd0, "no-vote byte not zero")
    `TBV_ASSERT_IMP(a_corr_le_err, res_valid, res.corrected_total <= res.error_total, "corrected count above error count")
    `TBV_ASSERT_IMP(a_err_mono, res_valid && $past(res_valid) && $past(rst_n), res.error_total >= $past(res.error_total), "error count went down")

endmodule

bind tmr_byte_voter_unit tbv_checker u_tbv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res       (result.data)
);

// ===== sim/tmr_byte_voter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_byte_voter_unit_test
// Self-checking bench for the triple-redundant byte voter. A scoreboard class
// predicts every vote from the RAM window, the latched copy mask and the
// counters. Directed runs cover the corner cases, then random runs follow
// across several windows. Both channels stall at random, with one long
// result-side hold-off that backs the pipe up into the item channel.
// ----------------------------------------------------------------------------
module tmr_byte_voter_unit_test;

    import tbv_pkg::*;

    localparam int VOTE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_AT      = 90;

    class vote_scoreboard;
        logic [CFG_DATA_BITS-1:0] ram_low;
        logic [CFG_DATA_BITS-1:0] ram_high;
        copy_mask_t               copy_mode;
        logic                     healthy;
        logic [TOTAL_BITS-1:0]    error_count;
        logic [TOTAL_BITS-1:0]    fixed_count;
        result_t                  expected_votes[$];
        int                       errors;

        function new();
            ram_low     = '0;
            ram_high    = '1;
            copy_mode   = MASK_NONE;
            healthy     = 1'b1;
            error_count = '0;
            fixed_count = '0;
            errors      = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] value);
            if (idx == REG_RAM_LOW)
            begin
                ram_low = value;
            end
            else if (idx == REG_RAM_HIGH)
            begin
                ram_high = value;
            end
        endfunction

        function bit addr_ok(logic [ADDR_FIELD_BITS-1:0] addr);
            return (ram_low <= addr) && (addr <= ram_high);
        endfunction

        function logic [TOTAL_BITS-1:0] bump(logic [TOTAL_BITS-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function int pending();
            return expected_votes.size();
        endfunction

        // predict the vote for one accepted byte triple
        function void note_triple(item_t it);
            result_t    r;
            logic [7:0] x;
            logic [7:0] y;
            r = '0;
            if (it.first)
            begin
                copy_mode = {addr_ok(it.addr_c), addr_ok(it.addr_b), addr_ok(it.addr_a)};
                healthy   = 1'b1;
                if ($countones(copy_mode) < 2)
                begin
                    error_count = bump(error_count);
                    healthy     = 1'b0;
                end
            end
            if (copy_mode == MASK_ABC)
            begin
                r.voted_byte = (it.byte_a & it.byte_b) | (it.byte_a & it.byte_c) |
                               (it.byte_b & it.byte_c);
                r.mismatch   = (it.byte_a != it.byte_b) || (it.byte_a != it.byte_c);
                r.fatal      = (it.byte_a != it.byte_b) && (it.byte_a != it.byte_c) &&
                               (it.byte_b != it.byte_c);
                if (r.mismatch)
                begin
                    error_count = bump(error_count);
                    fixed_count = bump(fixed_count);
                end
                if (r.fatal)
                begin
                    healthy = 1'b0;
                end
            end
            else if ($countones(copy_mode) == 2)
            begin
                if (copy_mode == MASK_BC)
                begin
                    x = it.byte_b;
                    y = it.byte_c;
                end
                else if (copy_mode == MASK_AC)
                begin
                    x = it.byte_a;
                    y = it.byte_c;
                end
                else
                begin
                    x = it.byte_a;
                    y = it.byte_b;
                end
                r.voted_byte = x;
                r.mismatch   = (x != y);
                r.fatal      = (x != y);
                if (r.mismatch)
                begin
                    error_count = bump(error_count);
                    fixed_count = bump(fixed_count);
                    healthy     = 1'b0;
                end
            end
            else
            begin
                // too few copies: fatal on every byte, nothing counted here
                r.fatal = 1'b1;
                healthy = 1'b0;
            end
            r.run_end         = it.last;
            r.run_good        = it.last && healthy;
            r.error_total     = error_count;
            r.corrected_total = fixed_count;
            expected_votes.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_vote(result_t got);
            result_t want;
            if (expected_votes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = expected_votes.pop_front();
            field_check("voted_byte", want.voted_byte, got.voted_byte);
            field_check("mismatch", want.mismatch, got.mismatch);
            field_check("fatal", want.fatal, got.fatal);
            field_check("run_end", want.run_end, got.run_end);
            field_check("run_good", want.run_good, got.run_good);
            field_check("error_total", want.error_total, got.error_total);
            field_check("corrected_total", want.corrected_total, got.corrected_total);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    tbv_stream_if #(.T(item_t))   item_ch ();
    tbv_stream_if #(.T(result_t)) result_ch ();

    vote_scoreboard board = new();

    int  cycles   = 0;
    int  tx_count = 0;
    int  rx_count = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    tmr_byte_voter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tmr_byte_voter_unit_test: done, errors");
            $finish;
        end
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic item_t make_triple(logic f, logic l,
                                          logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                          logic [7:0] x, logic [7:0] y, logic [7:0] z);
        item_t it;
        it.first  = f;
        it.last   = l;
        it.addr_a = a;
        it.addr_b = b;
        it.addr_c = c;
        it.byte_a = x;
        it.byte_b = y;
        it.byte_c = z;
        return it;
    endfunction

    // address inside or outside the current window, boundaries favored
    function automatic logic [31:0] pick_addr(bit in_win);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = board.ram_low;
        hi = board.ram_high;
        if (lo > hi)
        begin
            return $urandom;
        end
        if (in_win)
        begin
            case ($urandom_range(0, 5))
                0: return lo;
                1: return hi;
                default: return $urandom_range(hi, lo);
            endcase
        end
        if (lo != 0 && (hi == '1 || $urandom_range(0, 1) == 1))
        begin
            return ($urandom_range(0, 3) == 0) ? lo - 1 : $urandom_range(lo - 1, 0);
        end
        if (hi != '1)
        begin
            return ($urandom_range(0, 3) == 0) ? hi + 1 : $urandom_range(32'hFFFF_FFFF, hi + 1);
        end
        return $urandom;
    endfunction

    function automatic logic [7:0] spoil(logic [7:0] b);
        if ($urandom_range(0, 5) != 0)
        begin
            return b;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return b ^ (8'h01 << $urandom_range(0, 7));
        end
        return b ^ 8'($urandom_range(1, 255));
    endfunction

    task automatic send_triple(input item_t it);
        int gap;
        gap = draw_wait(tx_quiet);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        board.note_triple(it);
        tx_count++;
        if (tx_count % 40 == 0)
        begin
            tx_quiet = ($urandom_range(0, 2) == 0);
        end
    endtask

    task automatic write_window(input logic [31:0] lo, input logic [31:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RAM_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        board.set_register(REG_RAM_LOW, lo);
        cfg_index <= REG_RAM_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        board.set_register(REG_RAM_HIGH, hi);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge clk);
        repeat (VOTE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic directed_runs();
        write_window(32'h0000_0100, 32'hFFFF_FF00);
        // before any first mark the mask is empty
        send_triple(make_triple(0, 0, 32'h0, 32'h0, 32'h0, 8'h12, 8'h12, 8'h12));
        send_triple(make_triple(0, 1, '1, '1, '1, 8'h34, 8'h35, 8'h36));
        // three copies, window edges
        send_triple(make_triple(1, 0, 32'h100, 32'hFFFF_FF00, 32'h8000_0000,
                                8'h00, 8'h00, 8'h00));
        send_triple(make_triple(0, 0, 32'h0, 32'h0, 32'h0, 8'hFF, 8'hFF, 8'hFF));
        send_triple(make_triple(0, 0, 32'h0, 32'h0, 32'h0, 8'h0F, 8'hF0, 8'hF0));
        send_triple(make_triple(0, 0, 32'h0, 32'h0, 32'h0, 8'h3C, 8'h3C, 8'hC3));
        send_triple(make_triple(0, 0, 32'h0, 32'h0, 32'h0, 8'h5A, 8'hA5, 8'h5A));
        send_triple(make_triple(0, 0, 32'h0, 32'h0, 32'h0, 8'h01, 8'h02, 8'h04));
        send_triple(make_triple(0, 1, 32'h0, 32'h0, 32'h0, 8'hAA, 8'hAA, 8'hAA));
        // bytes after a last keep the latched mask
        send_triple(make_triple(0, 0, 32'h0, 32'h0, 32'h0, 8'h77, 8'h77, 8'h78));
        send_triple(make_triple(1, 1, 32'h100, 32'h100, 32'h100, 8'h80, 8'h80, 8'h80));
        // two-copy pairs
        send_triple(make_triple(1, 0, 32'h100, 32'h200, 32'hFFFF_FF01, 8'h11, 8'h11, 8'h99));
        send_triple(make_triple(0, 1, 32'h0, 32'h0, 32'h0, 8'h11, 8'h12, 8'h11));
        send_triple(make_triple(1, 0, 32'h8000_0000, 32'hFF, 32'hFFFF_FF00,
                                8'h21, 8'h00, 8'h21));
        send_triple(make_triple(0, 1, 32'h0, 32'h0, 32'h0, 8'h21, 8'h00, 8'h20));
        send_triple(make_triple(1, 0, 32'h0, 32'h100, 32'hFFFF_FF00, 8'hFF, 8'h44, 8'h44));
        send_triple(make_triple(0, 1, 32'h0, 32'h0, 32'h0, 8'h00, 8'h44, 8'h45));
        // too few copies, then one three-copy run at the window edges
        send_triple(make_triple(1, 0, 32'h100, '1, 32'h0, 8'h66, 8'h66, 8'h66));
        send_triple(make_triple(0, 1, 32'h0, 32'h0, 32'h0, 8'h66, 8'h67, 8'h68));
        send_triple(make_triple(1, 1, 32'hFF, 32'hFFFF_FF01, '1, 8'h09, 8'h09, 8'h09));
        send_triple(make_triple(1, 1, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'h100,
                                8'hFF, 8'h00, 8'hFF));
        item_ch.valid <= 1'b0;
        wait_drained();
    endtask

    // mostly well-formed runs with random content, some noise and cut runs
    task automatic random_runs(input logic [31:0] lo, input logic [31:0] hi,
                               input int count);
        int          sent;
        int          len;
        int          k;
        bit          cut;
        logic [31:0] aa;
        logic [31:0] ab;
        logic [31:0] ac;
        logic [7:0]  base;
        item_t       it;
        write_window(lo, hi);
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                it = make_triple(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom, $urandom, $urandom,
                                 8'($urandom), 8'($urandom), 8'($urandom));
                send_triple(it);
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                cut = ($urandom_range(0, 11) == 0);
                aa  = pick_addr($urandom_range(0, 7) != 0);
                ab  = pick_addr($urandom_range(0, 7) != 0);
                ac  = pick_addr($urandom_range(0, 7) != 0);
                for (k = 0; k < len; k++)
                begin
                    base = 8'($urandom);
                    it = make_triple(k == 0, (k == len - 1) && !cut,
                                     (k == 0) ? aa : $urandom,
                                     (k == 0) ? ab : $urandom,
                                     (k == 0) ? ac : $urandom,
                                     spoil(base), spoil(base), spoil(base));
                    send_triple(it);
                    sent++;
                end
            end
        end
        item_ch.valid <= 1'b0;
        wait_drained();
    endtask

    // result side; one long hold-off lets the pipe back up into the item channel
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall = (rx_count == HOLD_AT) ? LONG_HOLD : draw_wait(rx_quiet);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            board.check_vote(result_ch.data);
            rx_count++;
            if (rx_count % 48 == 0)
            begin
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
        end
    end

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] t;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_RAM_LOW;
        cfg_data      <= '0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_runs();
        random_runs(32'h0000_0000, 32'hFFFF_FFFF, 160);
        random_runs(32'h0000_1000, 32'h0000_1FFF, 160);
        random_runs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
        random_runs(32'h0000_0000, 32'h0000_0000, 100);
        // inverted window: no copy can be valid
        random_runs(32'h0000_2000, 32'h0000_1000, 60);
        lo = $urandom;
        hi = $urandom;
        if (lo > hi)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        random_runs(lo, hi, 220);

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("tmr_byte_voter_unit_test: done, clean");
        end
        else
        begin
            $display("tmr_byte_voter_unit_test: done, errors");
        end
        $finish;
    end

endmodule
